FILE: rtl/gfr_pkg.sv
// Package for the GOST 28147-89 round block: word types, codes and constants.
// No dependencies; used by gfr_round_fn and gost_feistel_round.
`default_nettype none

package gfr_pkg;

	localparam int NUM_ROWS   = 8;
	localparam int NUM_KEYS   = 8;
	localparam int NIB_W      = 4;
	localparam int HALF_W     = 32;
	localparam int ROW_W      = NIB_W * 16;
	localparam int KIDX_W     = $clog2(NUM_KEYS);
	localparam int CFG_IDX_W  = $clog2(NUM_ROWS);
	localparam int RND_W      = 6;
	localparam int ROT_AMT    = 11;

	// round number limits
	localparam logic [RND_W-1:0] FIRST_ROUND   = 6'd1;
	localparam logic [RND_W-1:0] FORWARD_LAST  = 6'd24;
	localparam logic [RND_W-1:0] LAST_ROUND    = 6'd32;

	typedef enum logic {
		CMD_ROUND = 1'b0,
		CMD_LOAD  = 1'b1
	} cmd_t;

	typedef logic [NUM_ROWS-1:0][ROW_W-1:0] sbox_rows_t;

	// input word
	typedef struct packed {
		cmd_t              cmd;
		logic [RND_W-1:0]  round_number;
		logic [HALF_W-1:0] first_half;
		logic [HALF_W-1:0] second_half;
		logic [KIDX_W-1:0] key_slot;
		logic [HALF_W-1:0] key_word;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [HALF_W-1:0] out_first;
		logic [HALF_W-1:0] out_second;
		logic [KIDX_W-1:0] used_key_index;
		logic [HALF_W-1:0] key_sum;
		logic [HALF_W-1:0] substituted;
		logic [HALF_W-1:0] rotated;
		logic              bad_round;
	} out_word_t;

	// intermediate values of the round function
	typedef struct packed {
		logic [HALF_W-1:0] sum;
		logic [HALF_W-1:0] sub;
		logic [HALF_W-1:0] rot;
		logic [HALF_W-1:0] f;
	} fn_vals_t;

endpackage

`default_nettype wire

FILE: rtl/gost_feistel_round.sv
// Top level of the GOST 28147-89 single-round block: key store, S-box rows,
// input stage and result register. Depends on gfr_pkg and gfr_round_fn.
//
//  channel   handshake          payload      notes
//  input     start / busy       item         accepted when start && !busy
//  result    done (1 cycle)     result       one word per round command
//  config    cfg_we             cfg_index,   S-box row write, no wait
//                               cfg_data
//
// A round word is accepted every cycle; busy is always low. Its result passes
// through the input register, then the add, S-box, rotate and XOR path into
// the result register. Load words write the key store at the accepting edge
// and give no result. Reset clears the key store, the S-box rows and the
// strobes. The receiver cannot stall the result.
`default_nettype none

module gost_feistel_round (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire gfr_pkg::in_word_t           item,
	output logic                             done,
	output gfr_pkg::out_word_t               result,
	input  wire logic                        cfg_we,
	input  wire logic [2:0]                  cfg_index,
	input  wire logic [63:0]                 cfg_data
);
	import gfr_pkg::*;

	sbox_rows_t        sbox_q;
	logic [HALF_W-1:0] key_q [NUM_KEYS];
	logic              valid_s1;
	in_word_t          word_s1;
	logic              accept;
	logic              bad;
	logic [RND_W-1:0]  back_idx;
	logic [KIDX_W-1:0] kidx;
	fn_vals_t          vals;
	out_word_t         res_d;
	out_word_t         result_q;
	logic              done_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// S-box rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbox_q <= '0;
		end else if (cfg_we) begin
			sbox_q[cfg_index[CFG_IDX_W-1:0]] <= cfg_data;
		end
	end

	// key store, written by load words at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				key_q[i] <= '0;
			end
		end else if (accept && item.cmd == CMD_LOAD) begin
			key_q[item.key_slot] <= item.key_word;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && item.cmd == CMD_ROUND;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= item;
		end
	end

	// key schedule: forward for the first 24 rounds, reversed for the rest
	assign bad      = (word_s1.round_number < FIRST_ROUND) ||
	                  (word_s1.round_number > LAST_ROUND);
	assign back_idx = LAST_ROUND - word_s1.round_number;

	always_comb begin
		if (word_s1.round_number <= FORWARD_LAST) begin
			kidx = KIDX_W'(word_s1.round_number - FIRST_ROUND);
		end else begin
			kidx = back_idx[KIDX_W-1:0];
		end
	end

	gfr_round_fn u_fn (
		.sbox_rows   (sbox_q),
		.first_half  (word_s1.first_half),
		.second_half (word_s1.second_half),
		.key         (key_q[kidx]),
		.vals        (vals)
	);

	// assemble the result word; last round keeps the halves in place
	always_comb begin
		res_d = '0;
		if (bad) begin
			res_d.bad_round = 1'b1;
		end else begin
			if (word_s1.round_number == LAST_ROUND) begin
				res_d.out_first  = word_s1.first_half;
				res_d.out_second = vals.f;
			end else begin
				res_d.out_first  = vals.f;
				res_d.out_second = word_s1.first_half;
			end
			res_d.used_key_index = kidx;
			res_d.key_sum        = vals.sum;
			res_d.substituted    = vals.sub;
			res_d.rotated        = vals.rot;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: rtl/gfr_round_fn.sv
// GOST round function: key add, per-nibble S-box substitution, rotate, XOR.
// Purely combinational; depends on gfr_pkg.
`default_nettype none

module gfr_round_fn (
	input  wire gfr_pkg::sbox_rows_t   sbox_rows,
	input  wire logic [31:0]           first_half,
	input  wire logic [31:0]           second_half,
	input  wire logic [31:0]           key,
	output gfr_pkg::fn_vals_t          vals
);
	import gfr_pkg::*;

	logic [HALF_W-1:0] sum;
	logic [HALF_W-1:0] sub;
	logic [HALF_W-1:0] rot;

	// modular add of the key word
	assign sum = first_half + key;

	// each nibble picks one entry of its own row
	always_comb begin
		for (int p = 0; p < NUM_ROWS; p++) begin
			sub[p*NIB_W +: NIB_W] = sbox_rows[p][sum[p*NIB_W +: NIB_W]*NIB_W +: NIB_W];
		end
	end

	assign rot = {sub[HALF_W-ROT_AMT-1:0], sub[HALF_W-1:HALF_W-ROT_AMT]};

	assign vals.sum = sum;
	assign vals.sub = sub;
	assign vals.rot = rot;
	assign vals.f   = rot ^ second_half;

endmodule

`default_nettype wire

FILE: verif/gost_feistel_round_check.sv
`timescale 1ns / 1ps
// Result checker for gost_feistel_round: mirrors the S-box rows and key store,
// predicts each round word and compares it with the result strobe. Uses gfr_pkg.

module gost_feistel_round_check import gfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  in_word_t             item,
	input  logic                 done,
	input  out_word_t            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0]     cfg_data,
	output int                   faults,
	output int                   checked,
	output int                   outstanding
);

	localparam int MAX_REPORTS = 10;

	sbox_rows_t        sbox;
	logic [HALF_W-1:0] key_bank [NUM_KEYS];
	out_word_t         round_words_due [$];
	out_word_t         due;

	// one GOST round on the mirrored key store and S-box rows
	function automatic out_word_t predict_round(in_word_t w);
		out_word_t         r;
		logic [KIDX_W-1:0] kidx;
		logic [HALF_W-1:0] sum;
		logic [HALF_W-1:0] sub;
		logic [HALF_W-1:0] rot;
		logic [NIB_W-1:0]  nib;
		r = '0;
		if (w.round_number < FIRST_ROUND || w.round_number > LAST_ROUND) begin
			r.bad_round = 1'b1;
			return r;
		end
		// keys run forward for rounds 1-24, backward for 25-32
		if (w.round_number <= FORWARD_LAST)
			kidx = KIDX_W'(w.round_number - FIRST_ROUND);
		else
			kidx = KIDX_W'(LAST_ROUND - w.round_number);
		sum = w.first_half + key_bank[kidx];
		for (int p = 0; p < NUM_ROWS; p++) begin
			nib = sum[p*NIB_W +: NIB_W];
			sub[p*NIB_W +: NIB_W] = sbox[p][nib*NIB_W +: NIB_W];
		end
		rot = (sub << ROT_AMT) | (sub >> (HALF_W - ROT_AMT));
		if (w.round_number == LAST_ROUND) begin
			r.out_first  = w.first_half;
			r.out_second = rot ^ w.second_half;
		end else begin
			r.out_first  = rot ^ w.second_half;
			r.out_second = w.first_half;
		end
		r.used_key_index = kidx;
		r.key_sum        = sum;
		r.substituted    = sub;
		r.rotated        = rot;
		return r;
	endfunction

	task automatic log_fault(string msg);
		faults++;
		if (faults <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic compare_field(string name, logic [HALF_W-1:0] want, logic [HALF_W-1:0] got);
		if (got !== want)
			log_fault($sformatf("%s: expected %h, got %h", name, want, got));
	endtask

	// config writes, result compare, then prediction of the newly accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbox = '0;
			for (int k = 0; k < NUM_KEYS; k++)
				key_bank[k] = '0;
			round_words_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				sbox[cfg_index] = cfg_data;
			if (done) begin
				if (round_words_due.size() == 0) begin
					log_fault($sformatf("result word with nothing due: %h", result));
				end else begin
					due = round_words_due.pop_front();
					checked++;
					compare_field("out_first", due.out_first, result.out_first);
					compare_field("out_second", due.out_second, result.out_second);
					compare_field("used_key_index", HALF_W'(due.used_key_index),
						HALF_W'(result.used_key_index));
					compare_field("key_sum", due.key_sum, result.key_sum);
					compare_field("substituted", due.substituted, result.substituted);
					compare_field("rotated", due.rotated, result.rotated);
					compare_field("bad_round", HALF_W'(due.bad_round),
						HALF_W'(result.bad_round));
				end
			end
			if (start && !busy) begin
				if (item.cmd == CMD_LOAD)
					key_bank[item.key_slot] = item.key_word;
				else
					round_words_due.push_back(predict_round(item));
			end
			outstanding <= round_words_due.size();
		end
	end

endmodule

FILE: verif/gost_feistel_round_test.sv
`timescale 1ns / 1ps
// Testbench top for gost_feistel_round: drives key loads, rounds and S-box
// settings; checking is done by gost_feistel_round_check. Uses gfr_pkg.

module gost_feistel_round_test;
	import gfr_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 12;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_DRAIN     = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int SETTINGS_RUN  = 7;
	localparam int RANDOM_ITEMS  = 140;
	localparam logic [CFG_IDX_W-1:0] SBOX_REG_BASE = '0;
	localparam logic [ROW_W-1:0]     IDENTITY_ROW  = 64'hFEDC_BA98_7654_3210;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	in_word_t             item      = '0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ROW_W-1:0]     cfg_data  = '0;
	logic                 busy;
	logic                 done;
	out_word_t            result;

	int faults;
	int checked;
	int outstanding;
	int cycle_count = 0;
	int good_rounds = 0;
	int bad_rounds  = 0;
	int key_loads   = 0;
	int settings    = 1;
	bit burst       = 1'b0;

	gost_feistel_round i_dut (
		.clk, .arst_n, .start, .busy, .item, .done, .result,
		.cfg_we, .cfg_index, .cfg_data
	);

	gost_feistel_round_check i_check (
		.clk, .arst_n, .start, .busy, .item, .done, .result,
		.cfg_we, .cfg_index, .cfg_data, .faults, .checked, .outstanding
	);

	always #HALF_PERIOD clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due",
				cycle_count, outstanding);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// mostly random, with the carry extremes now and then
	function automatic logic [HALF_W-1:0] wide_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_word_t make_round(logic [RND_W-1:0] rnd, logic [HALF_W-1:0] a,
			logic [HALF_W-1:0] b);
		in_word_t w;
		w.cmd          = CMD_ROUND;
		w.round_number = rnd;
		w.first_half   = a;
		w.second_half  = b;
		w.key_slot     = KIDX_W'($urandom);
		w.key_word     = $urandom;
		return w;
	endfunction

	function automatic in_word_t make_load(logic [KIDX_W-1:0] slot, logic [HALF_W-1:0] kw);
		in_word_t w;
		w.cmd          = CMD_LOAD;
		w.round_number = RND_W'($urandom);
		w.first_half   = $urandom;
		w.second_half  = $urandom;
		w.key_slot     = slot;
		w.key_word     = kw;
		return w;
	endfunction

	function automatic in_word_t random_word();
		int               pick;
		logic [RND_W-1:0] rnd;
		pick = $urandom_range(0, 99);
		if (pick < 16)
			return make_load(KIDX_W'($urandom), wide_value());
		if (pick < 26) begin
			// out-of-range round: zero or past the last round
			if ($urandom_range(0, 3) == 0)
				rnd = '0;
			else
				rnd = RND_W'($urandom_range(LAST_ROUND + 1, (1 << RND_W) - 1));
		end else begin
			rnd = RND_W'($urandom_range(FIRST_ROUND, LAST_ROUND));
		end
		return make_round(rnd, wide_value(), wide_value());
	endfunction

	// start stays high across back-to-back words
	task automatic send_word(input in_word_t w);
		start <= 1'b1;
		item  <= w;
		do @(posedge clk); while (busy);
		if (w.cmd == CMD_LOAD)
			key_loads++;
		else if (w.round_number < FIRST_ROUND || w.round_number > LAST_ROUND)
			bad_rounds++;
		else
			good_rounds++;
	endtask

	task automatic pause_sender();
		int n;
		int pick;
		pick = $urandom_range(0, 99);
		if (burst || pick < 45)
			n = 0;
		else if (pick < 88)
			n = $urandom_range(1, 3);
		else if (pick < 97)
			n = $urandom_range(4, 12);
		else
			n = $urandom_range(20, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// wait for every due result, then let the pipeline settle and empty
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_sbox(input sbox_rows_t rows);
		for (int r = 0; r < NUM_ROWS; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= SBOX_REG_BASE + CFG_IDX_W'(r);
			cfg_data  <= rows[r];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin
		sbox_rows_t rows;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: all-zero S-box rows and keys
		send_word(make_round(FIRST_ROUND, '1, '1));
		send_word(make_round(LAST_ROUND, '0, '0));
		send_word(make_round('0, $urandom, $urandom));
		drain();

		// transparent S-box, extreme keys in the end slots
		rows = {NUM_ROWS{IDENTITY_ROW}};
		program_sbox(rows);
		send_word(make_load('0, '1));
		for (int s = 1; s < NUM_KEYS - 1; s++)
			send_word(make_load(KIDX_W'(s), $urandom));
		send_word(make_load(KIDX_W'(NUM_KEYS - 1), '0));
		// key 0 is all ones: first half of 1 wraps the sum to zero
		send_word(make_round(FIRST_ROUND, 32'h1, '0));
		send_word(make_round(RND_W'(8), '1, '1));
		send_word(make_round(RND_W'(9), $urandom, '0));
		send_word(make_round(FORWARD_LAST, '0, '1));
		send_word(make_round(RND_W'(FORWARD_LAST + 1), $urandom, $urandom));
		send_word(make_round(RND_W'(LAST_ROUND - 1), '1, '0));
		send_word(make_round(LAST_ROUND, '1, '1));
		send_word(make_round(RND_W'(LAST_ROUND + 1), '1, '1));
		send_word(make_round('1, $urandom, $urandom));

		// random words under several S-box settings, extremes first
		for (int ph = 0; ph < SETTINGS_RUN; ph++) begin
			case (ph)
				0: rows = {NUM_ROWS{IDENTITY_ROW}};
				1: rows = '1;
				2: rows = '0;
				default: begin
					for (int r = 0; r < NUM_ROWS; r++)
						rows[r] = {$urandom, $urandom};
				end
			endcase
			drain();
			program_sbox(rows);
			for (int n = 0; n < RANDOM_ITEMS; n++) begin
				if (n % 35 == 0)
					burst = ($urandom_range(0, 3) == 0);
				send_word(random_word());
				pause_sender();
			end
		end

		start <= 1'b0;
		@(posedge clk);
		for (int c = 0; c < MAX_DRAIN && outstanding != 0; c++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d valid rounds, %0d out-of-range rounds and %0d key loads",
			good_rounds, bad_rounds, key_loads);
		$display("over %0d S-box settings; %0d result words checked, %0d faults, %0d missing",
			settings, checked, faults, outstanding);
		if (faults == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
